/* rtl/core/led_pkg.sv */
// Shared types and constants of the line editor.
package led_pkg;

	localparam logic [7:0] KEY_EOF    = 8'd4;
	localparam logic [7:0] KEY_NL     = 8'd10;
	localparam logic [7:0] KEY_KILL   = 8'd21;
	localparam logic [7:0] KEY_WERASE = 8'd23;
	localparam logic [7:0] KEY_BS     = 8'd127;
	localparam logic [7:0] KEY_PR_LO  = 8'd32;
	localparam logic [7:0] KEY_PR_HI  = 8'd126;

	localparam logic [6:0] CHAR_SPACE  = 7'h20;
	localparam logic [6:0] WIDTH_RESET = 7'd40;

	localparam int RESULT_CAP = 64;
	localparam int WORD_MAX   = RESULT_CAP - 3;
	localparam int ERASE_MAX  = 127;

	typedef enum logic [1:0] {
		ACT_ECHO    = 2'd0,
		ACT_ERASE   = 2'd1,
		ACT_BELL    = 2'd2,
		ACT_NEWLINE = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		OP_EOF    = 3'd0,
		OP_BS     = 3'd1,
		OP_KILL   = 3'd2,
		OP_WERASE = 3'd3,
		OP_NL     = 3'd4,
		OP_PRINT  = 3'd5,
		OP_OTHER  = 3'd6
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [6:0] ch;
	} entry_t;

endpackage

/* rtl/core/line_editor_with_word_wrap.sv */
// A key transfer is registered in the front end, passes the two-entry queue, is popped
// in S_IDLE and executed in S_EXEC; each result is registered and held while out_stall
// is high. Single-result keys pass S_IDLE and S_EXEC; word erase and a wrap add a backward
// scan of one character per cycle, and a wrap then gives one result per cycle while
// out_stall is low (moved word length + 3 results). Reset: line length cleared, width 40, queue empty; store kept.
// Top level of the line editor with word wrap.
module line_editor_with_word_wrap #(
	parameter int MAX_LINE = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wen,
	input  logic [6:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] key,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] action,
	output logic [6:0] echo_char,
	output logic [6:0] erase_count,
	output logic       session_end,
	output logic       last
);

	logic            push;
	led_pkg::entry_t push_data;
	logic            q_full;
	logic            pop;
	logic            q_valid;
	led_pkg::entry_t q_data;

	led_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.key       (key),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	led_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_data    (q_data)
	);

	led_back #(
		.MAX_LINE (MAX_LINE)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_wdata   (cfg_wdata),
		.q_valid     (q_valid),
		.q_data      (q_data),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.action      (action),
		.echo_char   (echo_char),
		.erase_count (erase_count),
		.session_end (session_end),
		.last        (last)
	);

endmodule

/* rtl/core/led_front.sv */
// Front end: takes key transfers, classifies them and pushes them to the queue.
module led_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       key,
	output logic             push,
	output led_pkg::entry_t  push_data,
	input  logic             q_full
);

	logic            valid_s1;
	led_pkg::entry_t entry_s1;
	led_pkg::entry_t cls;
	logic            accept;

	always_comb begin
		cls.ch = key[6:0];
		if (key == led_pkg::KEY_EOF) begin
			cls.op = led_pkg::OP_EOF;
		end else if (key == led_pkg::KEY_BS) begin
			cls.op = led_pkg::OP_BS;
		end else if (key == led_pkg::KEY_KILL) begin
			cls.op = led_pkg::OP_KILL;
		end else if (key == led_pkg::KEY_WERASE) begin
			cls.op = led_pkg::OP_WERASE;
		end else if (key == led_pkg::KEY_NL) begin
			cls.op = led_pkg::OP_NL;
		end else if (key >= led_pkg::KEY_PR_LO && key <= led_pkg::KEY_PR_HI) begin
			cls.op = led_pkg::OP_PRINT;
		end else begin
			cls.op = led_pkg::OP_OTHER;
		end
	end

	assign push      = valid_s1 && !q_full;
	assign in_stall  = valid_s1 && q_full;
	assign accept    = in_valid && !in_stall;
	assign push_data = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_s1 <= cls;
		end
	end

endmodule

/* rtl/core/led_queue.sv */
// Two-entry queue between the front end and the back end.
module led_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  led_pkg::entry_t  push_data,
	output logic             full,
	input  logic             pop,
	output logic             q_valid,
	output led_pkg::entry_t  q_data
);

	led_pkg::entry_t mem_q [2];
	logic            wptr_q;
	logic            rptr_q;
	logic [1:0]      count_q;

	assign full    = (count_q == 2'd2);
	assign q_valid = (count_q != 2'd0);
	assign q_data  = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

endmodule

/* rtl/core/led_back.sv */
// Back end: line store, edit sequencer and result register.
module led_back #(
	parameter int MAX_LINE = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wen,
	input  logic [6:0]       cfg_wdata,
	input  logic             q_valid,
	input  led_pkg::entry_t  q_data,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       action,
	output logic [6:0]       echo_char,
	output logic [6:0]       erase_count,
	output logic             session_end,
	output logic             last
);

	localparam int AW = $clog2(MAX_LINE);
	localparam int LW = $clog2(MAX_LINE + 1);
	localparam int CW = (LW > 7) ? LW : 7;

	typedef enum logic [10:0] {
		S_IDLE     = 11'b00000000001,
		S_EXEC     = 11'b00000000010,
		S_PREP     = 11'b00000000100,
		S_SCAN     = 11'b00000001000,
		S_DECIDE   = 11'b00000010000,
		S_NS_NL    = 11'b00000100000,
		S_NS_BELL  = 11'b00001000000,
		S_NS_KEY   = 11'b00010000000,
		S_WR_ERASE = 11'b00100000000,
		S_WR_NL    = 11'b01000000000,
		S_COPY     = 11'b10000000000
	} state_t;

	// word copy ends by appending the key in S_NS_KEY
	state_t state_q, state_d;
	logic   append_q, append_d;

	led_pkg::op_t op_q;
	logic [6:0]   k_q;
	logic [6:0]   width_q;
	logic [LW-1:0] len_q, len_d;
	logic [LW-1:0] p_q, p_d;
	logic [LW-1:0] e_q, e_d;
	logic [LW-1:0] s_q, s_d;
	logic [LW-1:0] i_q, i_d;
	logic          phase_q, phase_d;

	logic [6:0]    store [MAX_LINE];
	logic [6:0]    rdata_q;
	logic [LW-1:0] raddr_l;
	logic          we;
	logic [AW-1:0] waddr;
	logic [6:0]    wdata;

	logic             ovalid_q;
	led_pkg::action_t oact_q;
	logic [6:0]       och_q;
	logic [6:0]       ocnt_q;
	logic             oend_q;
	logic             olast_q;

	logic             can_emit;
	logic             emit;
	led_pkg::action_t e_act;
	logic [6:0]       e_ch;
	logic [6:0]       e_cnt;
	logic             e_end;
	logic             e_last;

	logic [CW-1:0] effw;
	logic          full;
	logic [LW-1:0] wl;
	logic          no_space;
	logic          too_long;
	logic          is_sp;

	function automatic logic [6:0] sat_cnt(input logic [LW-1:0] v);
		logic [CW-1:0] x;
		x = CW'(v);
		sat_cnt = (x > CW'(led_pkg::ERASE_MAX)) ? 7'(led_pkg::ERASE_MAX) : x[6:0];
	endfunction

	always_comb begin
		effw = CW'(width_q);
		if (width_q == 7'd0) begin
			effw = CW'(1);
		end else if (CW'(width_q) > CW'(MAX_LINE)) begin
			effw = CW'(MAX_LINE);
		end
	end

	assign full     = (CW'(len_q) >= effw);
	assign wl       = e_q - s_q;
	assign no_space = (e_q == len_q) && (s_q == '0);
	assign too_long = (CW'(wl) > CW'(led_pkg::WORD_MAX));
	assign is_sp    = (rdata_q == led_pkg::CHAR_SPACE);
	assign can_emit = !ovalid_q || !out_stall;

	always_comb begin
		state_d  = state_q;
		append_d = append_q;
		len_d    = len_q;
		p_d      = p_q;
		e_d      = e_q;
		s_d      = s_q;
		i_d      = i_q;
		phase_d  = phase_q;
		pop      = 1'b0;
		emit     = 1'b0;
		e_act    = led_pkg::ACT_ECHO;
		e_ch     = 7'd0;
		e_cnt    = 7'd0;
		e_end    = 1'b0;
		e_last   = 1'b0;
		we       = 1'b0;
		waddr    = '0;
		wdata    = k_q;
		raddr_l  = s_q;
		unique case (state_q)
			S_IDLE: begin
				append_d = 1'b0;
				if (q_valid) begin
					pop     = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (op_q)
					led_pkg::OP_EOF: begin
						if (can_emit) begin
							emit    = 1'b1;
							e_last  = 1'b1;
							e_act   = (len_q == '0) ? led_pkg::ACT_NEWLINE : led_pkg::ACT_BELL;
							e_end   = (len_q == '0);
							state_d = S_IDLE;
						end
					end
					led_pkg::OP_BS: begin
						if (can_emit) begin
							emit    = 1'b1;
							e_last  = 1'b1;
							state_d = S_IDLE;
							if (len_q == '0) begin
								e_act = led_pkg::ACT_BELL;
							end else begin
								e_act = led_pkg::ACT_ERASE;
								e_cnt = 7'd1;
								len_d = len_q - LW'(1);
							end
						end
					end
					led_pkg::OP_KILL: begin
						if (len_q == '0) begin
							state_d = S_IDLE;
						end else if (can_emit) begin
							emit    = 1'b1;
							e_last  = 1'b1;
							e_act   = led_pkg::ACT_ERASE;
							e_cnt   = sat_cnt(len_q);
							len_d   = '0;
							state_d = S_IDLE;
						end
					end
					led_pkg::OP_WERASE: begin
						state_d = S_PREP;
					end
					led_pkg::OP_NL: begin
						if (can_emit) begin
							emit    = 1'b1;
							e_last  = 1'b1;
							e_act   = led_pkg::ACT_NEWLINE;
							len_d   = '0;
							state_d = S_IDLE;
						end
					end
					led_pkg::OP_PRINT: begin
						if (full) begin
							state_d = S_PREP;
						end else if (can_emit) begin
							emit    = 1'b1;
							e_last  = 1'b1;
							e_act   = led_pkg::ACT_ECHO;
							e_ch    = k_q;
							we      = 1'b1;
							waddr   = len_q[AW-1:0];
							len_d   = len_q + LW'(1);
							state_d = S_IDLE;
						end
					end
					default: begin
						if (can_emit) begin
							emit    = 1'b1;
							e_last  = 1'b1;
							e_act   = led_pkg::ACT_BELL;
							state_d = S_IDLE;
						end
					end
				endcase
			end
			S_PREP: begin
				raddr_l = len_q - LW'(1);
				p_d     = len_q;
				phase_d = 1'b0;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				// rdata_q holds store[p_q - 1]; next entry is fetched ahead
				raddr_l = p_q - LW'(2);
				if (!phase_q) begin
					if (p_q == '0) begin
						e_d     = '0;
						s_d     = '0;
						state_d = S_DECIDE;
					end else if (is_sp) begin
						p_d = p_q - LW'(1);
					end else begin
						e_d     = p_q;
						p_d     = p_q - LW'(1);
						phase_d = 1'b1;
					end
				end else begin
					if (p_q == '0) begin
						s_d     = '0;
						state_d = S_DECIDE;
					end else if (!is_sp) begin
						p_d = p_q - LW'(1);
					end else begin
						s_d     = p_q;
						state_d = S_DECIDE;
					end
				end
			end
			S_DECIDE: begin
				if (op_q == led_pkg::OP_WERASE) begin
					if (len_q == s_q) begin
						state_d = S_IDLE;
					end else if (can_emit) begin
						emit    = 1'b1;
						e_last  = 1'b1;
						e_act   = led_pkg::ACT_ERASE;
						e_cnt   = sat_cnt(len_q - s_q);
						len_d   = s_q;
						state_d = S_IDLE;
					end
				end else if (no_space || too_long) begin
					state_d = S_NS_NL;
				end else begin
					state_d = S_WR_ERASE;
				end
			end
			S_NS_NL: begin
				if (can_emit) begin
					emit    = 1'b1;
					e_act   = led_pkg::ACT_NEWLINE;
					state_d = S_NS_BELL;
				end
			end
			S_NS_BELL: begin
				if (can_emit) begin
					emit    = 1'b1;
					e_act   = led_pkg::ACT_BELL;
					state_d = S_NS_KEY;
				end
			end
			S_NS_KEY: begin
				if (can_emit) begin
					emit    = 1'b1;
					e_last  = 1'b1;
					e_act   = led_pkg::ACT_ECHO;
					e_ch    = k_q;
					we      = 1'b1;
					if (append_q) begin
						waddr = wl[AW-1:0];
						len_d = wl + LW'(1);
					end else begin
						waddr = '0;
						len_d = LW'(1);
					end
					state_d = S_IDLE;
				end
			end
			S_WR_ERASE: begin
				if (can_emit) begin
					emit    = 1'b1;
					e_act   = led_pkg::ACT_ERASE;
					e_cnt   = sat_cnt(len_q - s_q);
					state_d = S_WR_NL;
				end
			end
			S_WR_NL: begin
				raddr_l = s_q;
				if (can_emit) begin
					emit     = 1'b1;
					e_act    = led_pkg::ACT_NEWLINE;
					i_d      = '0;
					append_d = 1'b1;
					state_d  = (wl == '0) ? S_NS_KEY : S_COPY;
				end
			end
			S_COPY: begin
				raddr_l = s_q + i_q + LW'(can_emit);
				if (can_emit) begin
					emit  = 1'b1;
					e_act = led_pkg::ACT_ECHO;
					e_ch  = rdata_q;
					we    = 1'b1;
					waddr = i_q[AW-1:0];
					wdata = rdata_q;
					i_d   = i_q + LW'(1);
					if (i_q + LW'(1) == wl) begin
						state_d = S_NS_KEY;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			append_q <= 1'b0;
			len_q    <= '0;
			width_q  <= led_pkg::WIDTH_RESET;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			append_q <= append_d;
			len_q    <= len_d;
			if (cfg_wen) begin
				width_q <= cfg_wdata;
			end
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		p_q     <= p_d;
		e_q     <= e_d;
		s_q     <= s_d;
		i_q     <= i_d;
		phase_q <= phase_d;
		if (pop) begin
			op_q <= q_data.op;
			k_q  <= q_data.ch;
		end
		if (emit) begin
			oact_q  <= e_act;
			och_q   <= e_ch;
			ocnt_q  <= e_cnt;
			oend_q  <= e_end;
			olast_q <= e_last;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			store[waddr] <= wdata;
		end
		rdata_q <= store[raddr_l[AW-1:0]];
	end

	assign out_valid   = ovalid_q;
	assign action      = oact_q;
	assign echo_char   = och_q;
	assign erase_count = ocnt_q;
	assign session_end = oend_q;
	assign last        = olast_q;

`ifndef SYNTHESIS
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!ovalid_q || !out_stall))
		else $error("result emitted over a held result");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == S_IDLE && q_valid))
		else $error("queue popped outside idle");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && e_last) |=> (state_q == S_IDLE))
		else $error("sequencer busy after final result");
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(len_q) <= CW'(MAX_LINE))
		else $error("line length beyond store");
	a_copy_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COPY) |-> (i_q < wl))
		else $error("word copy past word end");
`endif

endmodule
